[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hw/rtl/pwm_pkg.sv]
package pwm_pkg;

    localparam int ADDR_W    = 13;
    localparam int ENTRY_W   = 12;
    localparam int CH_W      = 5;
    localparam int SCALE_W   = 8;
    localparam int PROD_W    = CH_W + SCALE_W;
    localparam int IDX_W     = 13;
    localparam int WORD_W    = 16;
    localparam int SEL_W     = 2;
    localparam int BURST_MAX = 4;
    localparam int PTR_W     = $clog2(BURST_MAX);
    localparam int CNT_W     = PTR_W + 1;

    localparam int PALETTE_ENTRIES  = 4096;
    localparam int TILE_SLOTS       = 128;
    localparam int TILE_SLOT_SIZE   = 16;
    localparam int TILE_STRIDE      = 8;
    localparam int SPRITE_BASE      = 2048;
    localparam int SPRITE_SLOTS     = 256;
    localparam int SPRITE_SLOT_SIZE = 16;

    localparam int TILE_LIMIT = TILE_SLOTS * TILE_STRIDE + TILE_STRIDE;
    localparam int SPRITE_END = SPRITE_BASE + SPRITE_SLOTS * SPRITE_SLOT_SIZE;

    localparam logic [SEL_W-1:0] SEL_MAIN   = 2'd0;
    localparam logic [SEL_W-1:0] SEL_TILE   = 2'd1;
    localparam logic [SEL_W-1:0] SEL_SPRITE = 2'd2;

    typedef struct packed {
        logic [SEL_W-1:0]  sel;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] word;
    } t_write;

    function automatic logic [WORD_W-1:0] pack5551(input logic [CH_W-1:0] r,
                                                   input logic [CH_W-1:0] g,
                                                   input logic [CH_W-1:0] b);
        return {r, g, b, 1'b1};
    endfunction

    // Exact quotient by 255 for any product of a channel and the scale.
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] s;
        s = {1'b0, x} + (PROD_W+1)'(x >> 8) + (PROD_W+1)'(1);
        return s[CH_W+7:8];
    endfunction

endpackage

[hw/rtl/pwm_if.sv]
interface pwm_req_if import pwm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] palette_address;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;

    modport source (output valid, palette_address, red, green, blue, input ready);
    modport sink   (input valid, palette_address, red, green, blue, output ready);
endinterface

interface pwm_wr_if import pwm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [SEL_W-1:0]  table_select;
    logic [IDX_W-1:0]  entry_index;
    logic [WORD_W-1:0] color_word;
    logic              last;

    modport source (output valid, table_select, entry_index, color_word, last, input ready);
    modport sink   (input valid, table_select, entry_index, color_word, last, output ready);
endinterface

[hw/rtl/palette_write_mirror_top.sv]
// An accepted request is registered in stage 1, then stage 2, then the burst buffer.
// Throughput: one table write per cycle on the result channel while o_wr.ready is high;
// a request's burst holds two to four writes; the stages upstream accept a request
// every cycle while there is room.
// Reset: synchronous, active low; r_scale returns to 0 and every stage empties.
`include "assert_macros.svh"

module palette_write_mirror_top import pwm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_wdata,
    pwm_req_if.sink            i_req,
    pwm_wr_if.source           o_wr
);

    logic [SCALE_W-1:0] r_scale;

    logic               r_v1;
    logic [ENTRY_W-1:0] r_entry1;
    logic [WORD_W-1:0]  r_color1;
    logic [PROD_W-1:0]  r_pr1, r_pg1, r_pb1;

    logic               r_v2;
    t_write             r_list2 [BURST_MAX];
    logic [CNT_W-1:0]   r_cnt2;

    logic               r_vb;
    t_write             r_listb [BURST_MAX];
    logic [CNT_W-1:0]   r_cntb;
    logic [PTR_W-1:0]   r_ptr;

    t_write             n_list2 [BURST_MAX];
    logic [CNT_W-1:0]   n_cnt2;

    logic               rdy1, rdy2, rdyb, w_last;
    logic [ENTRY_W-1:0] n_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= '0;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    // Stage 1: entry, packed colour and the three shadow products.
    assign n_entry     = i_req.palette_address[ADDR_W-1:1];
    assign rdy1        = !r_v1 || rdy2;
    assign i_req.ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_req.valid;
        end
        if (rdy1 && i_req.valid) begin
            r_entry1 <= n_entry;
            r_color1 <= pack5551(i_req.red, i_req.green, i_req.blue);
            r_pr1    <= PROD_W'(i_req.red) * PROD_W'(r_scale);
            r_pg1    <= PROD_W'(i_req.green) * PROD_W'(r_scale);
            r_pb1    <= PROD_W'(i_req.blue) * PROD_W'(r_scale);
        end
    end

    // Stage 2: build the burst of table writes in order.
    always_comb begin
        logic              zero_entry;
        logic              in_tile, in_sprite;
        logic [8:0]        hi;
        logic [2:0]        pos;
        logic [ENTRY_W-1:0] rel;
        logic [WORD_W-1:0] shadow;
        t_write            cand [5];
        logic [4:0]        en;

        zero_entry = (r_entry1 == '0);
        hi         = r_entry1[ENTRY_W-1:3];
        pos        = r_entry1[2:0];
        rel        = r_entry1 - ENTRY_W'(SPRITE_BASE);
        in_tile    = (IDX_W'(r_entry1) < IDX_W'(TILE_LIMIT));
        in_sprite  = ((ENTRY_W+2)'(r_entry1) >= (ENTRY_W+2)'(SPRITE_BASE)) &&
                     ((ENTRY_W+2)'(r_entry1) < (ENTRY_W+2)'(SPRITE_END));
        shadow     = pack5551(div255(r_pr1), div255(r_pg1), div255(r_pb1));

        cand[0] = '{SEL_MAIN, IDX_W'(r_entry1), zero_entry ? '0 : r_color1};
        cand[1] = '{SEL_MAIN, IDX_W'(r_entry1) + IDX_W'(PALETTE_ENTRIES),
                    zero_entry ? '0 : shadow};
        cand[2] = '{SEL_TILE, IDX_W'(hi) * IDX_W'(TILE_SLOT_SIZE) + IDX_W'(pos),
                    (pos == '0) ? '0 : r_color1};
        cand[3] = '{SEL_TILE, (IDX_W'(hi) - IDX_W'(1)) * IDX_W'(TILE_SLOT_SIZE)
                    + IDX_W'(TILE_STRIDE) + IDX_W'(pos), r_color1};
        cand[4] = '{SEL_SPRITE, IDX_W'(rel[ENTRY_W-1:4]) * IDX_W'(SPRITE_SLOT_SIZE)
                    + IDX_W'(rel[3:0]), (rel[3:0] == '0) ? '0 : r_color1};

        en[0] = 1'b1;
        en[1] = 1'b1;
        en[2] = !zero_entry && in_tile && (IDX_W'(hi) < IDX_W'(TILE_SLOTS));
        en[3] = !zero_entry && in_tile && (hi != '0);
        en[4] = !zero_entry && in_sprite;

        n_cnt2 = '0;
        for (int k = 0; k < BURST_MAX; k++) begin
            n_list2[k] = cand[0];
        end
        for (int k = 0; k < 5; k++) begin
            if (en[k] && (n_cnt2 < CNT_W'(BURST_MAX))) begin
                n_list2[n_cnt2[PTR_W-1:0]] = cand[k];
                n_cnt2 = n_cnt2 + CNT_W'(1);
            end
        end
    end

    assign rdy2 = !r_v2 || rdyb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
        if (rdy2 && r_v1) begin
            r_list2 <= n_list2;
            r_cnt2  <= n_cnt2;
        end
    end

    // Stage 3: burst buffer that hands out one table write per cycle while o_wr.ready is high.
    assign w_last = ((CNT_W'(r_ptr) + CNT_W'(1)) == r_cntb);
    assign rdyb   = !r_vb || (o_wr.ready && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb  <= 1'b0;
            r_ptr <= '0;
        end else if (rdyb) begin
            r_vb  <= r_v2;
            r_ptr <= '0;
        end else if (o_wr.ready) begin
            r_ptr <= r_ptr + PTR_W'(1);
        end
        if (rdyb && r_v2) begin
            r_listb <= r_list2;
            r_cntb  <= r_cnt2;
        end
    end

    assign o_wr.valid        = r_vb;
    assign o_wr.table_select = r_listb[r_ptr].sel;
    assign o_wr.entry_index  = r_listb[r_ptr].idx;
    assign o_wr.color_word   = r_listb[r_ptr].word;
    assign o_wr.last         = w_last;

    `ASSERT_IMPLIES(a_ptr_in_burst, i_clk, i_rst_n, r_vb, CNT_W'(r_ptr) < r_cntb, "write pointer beyond burst")
    `ASSERT_IMPLIES(a_burst_len, i_clk, i_rst_n, r_vb, r_cntb >= CNT_W'(2) && r_cntb <= CNT_W'(BURST_MAX), "burst length out of range")
    `ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n, r_vb && o_wr.ready && !w_last, r_vb && r_ptr == $past(r_ptr) + PTR_W'(1), "burst cut short")
    `ASSERT_NEXT(a_stage2_holds, i_clk, i_rst_n, r_v2 && !rdyb, r_v2 && r_cnt2 == $past(r_cnt2), "stalled request lost")

endmodule

[tb/palette_mirror_check.sv]
module palette_mirror_check import pwm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_wdata,
    pwm_req_if                 i_req,
    pwm_wr_if                  i_wr,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_requests,
    output int                 o_writes
);

    typedef struct packed {
        logic [SEL_W-1:0]  sel;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_table_write;

    t_table_write       pending_writes[$];
    logic [SCALE_W-1:0] shadow_scale;
    int                 fail_count = 0;
    int                 request_count = 0;
    int                 write_count = 0;

    assign o_fail_count = fail_count;
    assign o_requests   = request_count;
    assign o_writes     = write_count;

    function automatic logic [WORD_W-1:0] rgba_word(input logic [CH_W-1:0] r,
                                                    input logic [CH_W-1:0] g,
                                                    input logic [CH_W-1:0] b);
        return {r, g, b, 1'b1};
    endfunction

    function automatic void predict_table_writes(input logic [ADDR_W-1:0] addr,
                                                 input logic [CH_W-1:0]   r,
                                                 input logic [CH_W-1:0]   g,
                                                 input logic [CH_W-1:0]   b);
        t_table_write      burst[$];
        int                entry;
        int                hi;
        int                pos;
        int                rel;
        logic [WORD_W-1:0] colour;
        logic [WORD_W-1:0] shade;
        entry  = int'(addr >> 1);
        colour = rgba_word(r, g, b);
        shade  = rgba_word(CH_W'(int'(r) * int'(shadow_scale) / 255),
                           CH_W'(int'(g) * int'(shadow_scale) / 255),
                           CH_W'(int'(b) * int'(shadow_scale) / 255));
        if (entry == 0) begin
            burst.push_back(t_table_write'{SEL_MAIN, IDX_W'(0), WORD_W'(0), 1'b0});
            burst.push_back(t_table_write'{SEL_MAIN, IDX_W'(PALETTE_ENTRIES), WORD_W'(0),
                                           1'b0});
        end else begin
            burst.push_back(t_table_write'{SEL_MAIN, IDX_W'(entry), colour, 1'b0});
            burst.push_back(t_table_write'{SEL_MAIN, IDX_W'(entry + PALETTE_ENTRIES), shade,
                                           1'b0});
            if (entry < TILE_SLOTS * 8 + 8) begin
                hi  = entry >> 3;
                pos = entry & 7;
                if (hi < TILE_SLOTS) begin
                    burst.push_back(t_table_write'{SEL_TILE, IDX_W'(hi * TILE_SLOT_SIZE + pos),
                                                   (pos == 0) ? WORD_W'(0) : colour, 1'b0});
                end
                if (hi >= 1) begin
                    burst.push_back(t_table_write'{SEL_TILE,
                                                   IDX_W'((hi - 1) * TILE_SLOT_SIZE + 8 + pos),
                                                   colour, 1'b0});
                end
            end
            if (entry >= SPRITE_BASE &&
                entry < SPRITE_BASE + SPRITE_SLOTS * SPRITE_SLOT_SIZE) begin
                rel = entry - SPRITE_BASE;
                pos = rel & 15;
                burst.push_back(t_table_write'{SEL_SPRITE,
                                               IDX_W'((rel >> 4) * SPRITE_SLOT_SIZE + pos),
                                               (pos == 0) ? WORD_W'(0) : colour, 1'b0});
            end
        end
        while (burst.size() > BURST_MAX) begin
            void'(burst.pop_back());
        end
        burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) begin
            pending_writes.push_back(burst[i]);
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_table_write();
        t_table_write want;
        if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("table write with no request outstanding: sel=%0d idx=%0d word=%h last=%0b",
                                      i_wr.table_select, i_wr.entry_index, i_wr.color_word,
                                      i_wr.last));
        end else begin
            want = pending_writes.pop_front();
            if (i_wr.table_select !== want.sel || i_wr.entry_index !== want.idx ||
                i_wr.color_word !== want.word || i_wr.last !== want.last) begin
                report_mismatch($sformatf("sel %0d/%0d idx %0d/%0d word %h/%h last %0b/%0b (got/expected)",
                                          i_wr.table_select, want.sel, i_wr.entry_index,
                                          want.idx, i_wr.color_word, want.word, i_wr.last,
                                          want.last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_scale = '0;
            pending_writes.delete();
        end else begin
            if (i_cfg_we) begin
                shadow_scale = i_cfg_wdata;
            end
            if (i_req.valid && i_req.ready) begin
                predict_table_writes(i_req.palette_address, i_req.red, i_req.green,
                                     i_req.blue);
                request_count++;
            end
            if (i_wr.valid && i_wr.ready) begin
                check_table_write();
                write_count++;
            end
        end
        o_pending <= pending_writes.size();
    end

endmodule

[tb/tb.sv]
module tb;
    import pwm_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [SCALE_W-1:0] cfg_wdata;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    int                 fail_count;
    int                 writes_outstanding;
    int                 requests_seen;
    int                 writes_seen;

    logic [ADDR_W-1:0]   probe_addrs [18] = '{
        13'd0, 13'd1, 13'd2, 13'd15, 13'd16, 13'd17,
        13'd30, 13'd2046, 13'd2048, 13'd2063, 13'd2064, 13'd4094,
        13'd4096, 13'd4098, 13'd4126, 13'd4128, 13'd8190, 13'd8191
    };
    logic [3*CH_W-1:0]   probe_colours [18] = '{
        15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7C00, 15'h03E0, 15'h001F,
        15'h7FFF, 15'h5555, 15'h2AAA, 15'h7FFF, 15'h0421, 15'h7BDE,
        15'h7FFF, 15'h0000, 15'h7FFF, 15'h1234, 15'h7FFF, 15'h0000
    };

    pwm_req_if req ();
    pwm_wr_if  wr ();

    palette_write_mirror_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req),
        .o_wr       (wr)
    );

    palette_mirror_check mirror_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req),
        .i_wr        (wr),
        .o_fail_count(fail_count),
        .o_pending   (writes_outstanding),
        .o_requests  (requests_seen),
        .o_writes    (writes_seen)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        wr.ready = 1'b0;
        forever begin
            @(posedge clk);
            wr.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [CH_W-1:0] pick_channel();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            default: return CH_W'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        int kind;
        int entry;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            entry = 0;
        end else if (kind < 40) begin
            entry = $urandom_range(1, TILE_LIMIT - 1);
        end else if (kind < 55) begin
            entry = $urandom_range(0, 512) * 8 + $urandom_range(0, 1) * 7;
        end else if (kind < 70) begin
            entry = SPRITE_BASE + $urandom_range(0, 127) * 16 + $urandom_range(0, 1) * 15;
        end else begin
            return ADDR_W'($urandom_range(0, 8191));
        end
        return ADDR_W'((entry << 1) | $urandom_range(0, 1));
    endfunction

    task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [CH_W-1:0] r,
                                input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid           <= 1'b1;
        req.palette_address <= addr;
        req.red             <= r;
        req.green           <= g;
        req.blue            <= b;
        @(posedge clk);
        while (!req.ready) begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (writes_outstanding != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [SCALE_W-1:0] scale_setting;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req.valid           = 1'b0;
        req.palette_address = '0;
        req.red             = '0;
        req.green           = '0;
        req.blue            = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first few requests run at the reset scale of zero.
        for (int i = 0; i < 18; i++) begin
            if (i == 6) begin
                wait_drain();
                write_scale(8'd255);
            end
            send_request(probe_addrs[i], probe_colours[i][14:10], probe_colours[i][9:5],
                         probe_colours[i][4:0]);
        end

        for (int phase = 0; phase < 4; phase++) begin
            wait_drain();
            case (phase)
                0: begin
                    scale_setting = 8'd0;
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    scale_setting = 8'd128;
                    send_idle_pct = 88;
                    stall_pct     = 0;
                end
                2: begin
                    scale_setting = SCALE_W'($urandom_range(1, 254));
                    send_idle_pct = 0;
                    stall_pct     = 88;
                end
                default: begin
                    scale_setting = 8'd255;
                    send_idle_pct = 12;
                    stall_pct     = 12;
                end
            endcase
            write_scale(scale_setting);
            repeat (85) begin
                send_request(pick_address(), pick_channel(), pick_channel(), pick_channel());
            end
        end

        wait_drain();
        repeat (8) @(posedge clk);
        $display("Run covered %0d palette requests and %0d table writes, over six shadow scale",
                 requests_seen, writes_seen);
        $display("settings with free running, sender idle, receiver stall and mixed pacing.");
        if (fail_count == 0 && writes_outstanding == 0) begin
            $display("palette_write_mirror_top verification clean");
        end else begin
            $display("palette_write_mirror_top verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("palette_write_mirror_top verification failed");
        $finish;
    end

endmodule
